>>> sv/arq_pkg.sv
// ----------------------------------------------------------------------------
// arq_pkg: shared constants and helpers for the arcball rotation unit
// Widths of the fixed-point datapath, event and register codes, and the
// sign table of the quaternion product.
// ----------------------------------------------------------------------------
package arq_pkg;

    // coordinate and fixed-point formats
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 14;
    localparam int CFG_W      = 12;
    localparam int PT_W       = COORD_BITS + 1;
    localparam int Q_W        = 16;
    localparam int U_W        = FRAC_BITS + 4;
    localparam int CLAMP_SH   = FRAC_BITS + 8;
    localparam int PROD_SH    = FRAC_BITS - 8;
    localparam int L2_SH      = 16;

    // shared multiplier
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;

    // square root unit
    localparam int SQ_IN_W  = 64;
    localparam int SQ_OUT_W = SQ_IN_W / 2;
    localparam int SQ_CNT_W = $clog2(SQ_OUT_W + 1);

    // divider unit
    localparam int DIV_NUM_W = 50;
    localparam int DIV_DEN_W = 34;
    localparam int DIV_MAG_W = DIV_NUM_W + 1;
    localparam int DIV_Q_W   = DIV_MAG_W + 1;
    localparam int DIV_CNT_W = $clog2(DIV_MAG_W + 1);

    // constants
    localparam logic signed [Q_W-1:0]    QONE    = Q_W'(1 << FRAC_BITS);
    localparam logic signed [PROD_W-1:0] ONE_F   = PROD_W'(1) << FRAC_BITS;
    localparam logic signed [PROD_W-1:0] ONE_F2  = PROD_W'(1) << (2 * FRAC_BITS);
    localparam logic [CFG_W-1:0]         RAD_MIN = CFG_W'(2);

    // event kinds
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_PRESS   = 2'd0;
    localparam logic [OP_W-1:0] OP_MOVE    = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
    localparam logic [OP_W-1:0] OP_RESET   = 2'd3;

    // register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd2;

    // negated terms of p = q * o, term j of component i uses o[i ^ j]
    function automatic logic qp_neg(input logic [1:0] i, input logic [1:0] j);
        logic r;
        case ({i, j})
            4'b0001, 4'b0010, 4'b0011, 4'b0111, 4'b1001, 4'b1110: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

>>> sv/arq_sqrt.sv
// ----------------------------------------------------------------------------
// arq_sqrt: iterative integer square root
// Digit-by-digit floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module arq_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [arq_pkg::SQ_IN_W-1:0]   radicand,
    output logic                          done,
    output logic [arq_pkg::SQ_OUT_W-1:0]  root
);
    import arq_pkg::*;

    logic [SQ_IN_W-1:0]    val_reg;
    logic [SQ_OUT_W+1:0]   rem_reg;
    logic [SQ_OUT_W-1:0]   root_reg;
    logic [SQ_CNT_W-1:0]   cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [SQ_OUT_W+1:0]   rem_sh;
    logic [SQ_OUT_W+1:0]   trial;
    logic                  fits;

    // trial subtract of the next digit pair
    always_comb
    begin
        rem_sh = {rem_reg[SQ_OUT_W-1:0], val_reg[SQ_IN_W-1 -: 2]};
        trial  = {root_reg, 2'b01};
        fits   = rem_sh >= trial;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= SQ_CNT_W'(SQ_OUT_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == SQ_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg <= val_reg << 2;
            if (fits)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[SQ_OUT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[SQ_OUT_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> sv/arq_div.sv
// ----------------------------------------------------------------------------
// arq_div: iterative rounding divider
// Signed by positive division, rounded half away from zero, one quotient
// bit per cycle by restoring subtraction.
// ----------------------------------------------------------------------------
module arq_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [arq_pkg::DIV_NUM_W-1:0] num,
    input  logic [arq_pkg::DIV_DEN_W-1:0]        den,
    output logic                                 done,
    output logic signed [arq_pkg::DIV_Q_W-1:0]   quot
);
    import arq_pkg::*;

    logic [DIV_MAG_W-1:0]        dvd_reg;
    logic [DIV_DEN_W-1:0]        rem_reg;
    logic [DIV_DEN_W-1:0]        den_reg;
    logic                        neg_reg;
    logic [DIV_CNT_W-1:0]        cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic signed [DIV_MAG_W-1:0] num_ext;
    logic [DIV_MAG_W-1:0]        mag;
    logic [DIV_MAG_W-1:0]        dvd_init;
    logic [DIV_DEN_W:0]          rem_sh;
    logic [DIV_DEN_W:0]          diff;
    logic                        fits;

    // magnitude plus half divisor for rounding, and one restoring step
    always_comb
    begin
        num_ext  = DIV_MAG_W'(num);
        mag      = num_ext[DIV_MAG_W-1] ? DIV_MAG_W'(-num_ext) : DIV_MAG_W'(num_ext);
        dvd_init = mag + DIV_MAG_W'(den >> 1);
        rem_sh   = {rem_reg, dvd_reg[DIV_MAG_W-1]};
        diff     = rem_sh - {1'b0, den_reg};
        fits     = rem_sh >= {1'b0, den_reg};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(DIV_MAG_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // datapath: quotient bits shift in behind the dividend
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dvd_init;
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[DIV_NUM_W-1];
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DIV_MAG_W-2:0], fits};
            rem_reg <= fits ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});

endmodule

>>> sv/arcball_quaternion_rotation_unit.sv
// ----------------------------------------------------------------------------
// arcball_quaternion_rotation_unit: arcball drag to orientation quaternion
// Press, release and reset events go straight to the done state and are queued
// in the result stage once it is free. A move while dragging runs the divider
// (up to 11 passes) and the square root unit (up to 6 passes) in turn.
// One item is in work at a time; the next is taken once the result is queued.
// Reset (rst_n low) restores identity, ends any drag and reloads the registers.
// ----------------------------------------------------------------------------
module arcball_quaternion_rotation_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // pointer_x, pointer_y
    input  logic [arq_pkg::OP_W-1:0]        s_tuser,   // op
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [63:0]                     m_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic [0:0]                      m_tuser,   // rotated
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [arq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [arq_pkg::CFG_W-1:0]       cfg_data
);
    import arq_pkg::*;

    localparam int ST_W = 6;
    localparam logic [ST_W-1:0] ST_IDLE = 6'd0,  ST_DONE = 6'd1;
    localparam logic [ST_W-1:0] ST_P0 = 6'd2,  ST_P1 = 6'd3,  ST_P2 = 6'd4,  ST_P3 = 6'd5;
    localparam logic [ST_W-1:0] ST_P4 = 6'd6,  ST_P5 = 6'd7,  ST_P6 = 6'd8,  ST_P7 = 6'd9;
    localparam logic [ST_W-1:0] ST_P8 = 6'd10, ST_P9 = 6'd11, ST_P10 = 6'd12;
    localparam logic [ST_W-1:0] ST_I0 = 6'd13, ST_I1 = 6'd14, ST_I2 = 6'd15;
    localparam logic [ST_W-1:0] ST_Z0 = 6'd16, ST_Z1 = 6'd17, ST_Z2 = 6'd18, ST_Z3 = 6'd19;
    localparam logic [ST_W-1:0] ST_Z4 = 6'd20;
    localparam logic [ST_W-1:0] ST_D1 = 6'd21, ST_D2 = 6'd22, ST_D3 = 6'd23, ST_D4 = 6'd24;
    localparam logic [ST_W-1:0] ST_D5 = 6'd25, ST_D6 = 6'd26, ST_QS = 6'd27;
    localparam logic [ST_W-1:0] ST_C0 = 6'd28, ST_C1 = 6'd29, ST_C2 = 6'd30, ST_C3 = 6'd31;
    localparam logic [ST_W-1:0] ST_C4 = 6'd32, ST_C5 = 6'd33, ST_C6 = 6'd34, ST_C7 = 6'd35;
    localparam logic [ST_W-1:0] ST_C8 = 6'd36, ST_C9 = 6'd37, ST_C10 = 6'd38;
    localparam logic [ST_W-1:0] ST_M0 = 6'd39, ST_M1 = 6'd40, ST_M2 = 6'd41;
    localparam logic [ST_W-1:0] ST_N0 = 6'd42, ST_N1 = 6'd43, ST_N2 = 6'd44, ST_N3 = 6'd45;
    localparam logic [ST_W-1:0] ST_N4 = 6'd46, ST_N5 = 6'd47;

    // configuration
    logic [CFG_W-1:0]           rad_cfg_reg;
    logic [CFG_W-1:0]           cx_cfg_reg;
    logic [CFG_W-1:0]           cy_cfg_reg;

    // block state
    logic signed [Q_W-1:0]      orient_reg [4];
    logic signed [PT_W-1:0]     org_x_reg;
    logic signed [PT_W-1:0]     org_y_reg;
    logic                       dragging_reg;
    logic                       rot_reg;

    // sequencer and working registers
    logic [ST_W-1:0]            state_reg;
    logic signed [PT_W-1:0]     cur_x_reg;
    logic signed [PT_W-1:0]     cur_y_reg;
    logic signed [PT_W-1:0]     px_reg;
    logic signed [PT_W-1:0]     py_reg;
    logic                       pt_sel_reg;
    logic [CFG_W-1:0]           rad_reg;
    logic [2*CFG_W-1:0]         thr_reg;
    logic [DIV_DEN_W-1:0]       den_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   acc_reg;
    logic signed [U_W-1:0]      ux_reg;
    logic signed [U_W-1:0]      uy_reg;
    logic signed [U_W-1:0]      a_reg [3];
    logic signed [U_W-1:0]      b_reg [3];
    logic                       pos_reg;
    logic [SQ_OUT_W-1:0]        s_reg;
    logic [SQ_OUT_W-1:0]        n_reg;
    logic signed [MUL_W-1:0]    q_reg [4];
    logic signed [MUL_W-1:0]    p_reg [4];
    logic [1:0]                 i_reg;
    logic [1:0]                 j_reg;
    logic [1:0]                 k_reg;

    // result stage
    logic                       m_valid_reg;
    logic signed [Q_W-1:0]      out_q_reg [4];
    logic                       out_rot_reg;

    // shared units
    logic                       mul_en;
    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic                       sq_start;
    logic [SQ_IN_W-1:0]         sq_rad;
    logic                       sq_done;
    logic [SQ_OUT_W-1:0]        sq_root;
    logic                       div_start;
    logic signed [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0]       div_den;
    logic                       div_done;
    logic signed [DIV_Q_W-1:0]  div_quot;

    // misc combinational values
    logic [CFG_W-1:0]           sr;
    logic signed [PT_W-1:0]     in_x;
    logic signed [PT_W-1:0]     in_y;
    logic signed [PROD_W-1:0]   t_val;
    logic signed [PROD_W-1:0]   term;
    logic                       in_fire;
    logic                       out_load;

    // rounded arithmetic shift right, half away from zero
    function automatic logic signed [PROD_W-1:0] rnd_shr(
        input logic signed [PROD_W-1:0] v, input int sh);
        logic [PROD_W-1:0] m;
        m = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
        m = (m + (PROD_W'(1) << (sh - 1))) >> sh;
        return v[PROD_W-1] ? -$signed(m) : $signed(m);
    endfunction

    always_comb
    begin
        sr      = rad_reg - 1'b1;
        in_x    = $signed({1'b0, s_tdata[CFG_W-1:0]}) - $signed({1'b0, cx_cfg_reg});
        in_y    = $signed({1'b0, s_tdata[2*CFG_W-1:CFG_W]}) - $signed({1'b0, cy_cfg_reg});
        t_val   = ONE_F + rnd_shr(acc_reg, FRAC_BITS);
        term    = qp_neg(i_reg, j_reg) ? -prod_reg : prod_reg;
        in_fire = s_tvalid && s_tready;
        out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);
    end

    // operand select of the shared multiplier
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_P0: begin mul_en = 1'b1; mul_a = $signed(MUL_W'(sr)); mul_b = $signed(MUL_W'(sr)); end
            ST_P1: begin mul_en = 1'b1; mul_a = MUL_W'(px_reg); mul_b = MUL_W'(px_reg); end
            ST_P2: begin mul_en = 1'b1; mul_a = MUL_W'(py_reg); mul_b = MUL_W'(py_reg); end
            ST_P6: begin mul_en = 1'b1; mul_a = $signed(sq_root); mul_b = $signed(MUL_W'(rad_reg)); end
            ST_P7: begin mul_en = 1'b1; mul_a = MUL_W'(px_reg); mul_b = $signed(MUL_W'(sr)); end
            ST_P8: begin mul_en = 1'b1; mul_a = MUL_W'(py_reg); mul_b = $signed(MUL_W'(sr)); end
            ST_Z0: begin mul_en = 1'b1; mul_a = MUL_W'(ux_reg); mul_b = MUL_W'(ux_reg); end
            ST_Z1: begin mul_en = 1'b1; mul_a = MUL_W'(uy_reg); mul_b = MUL_W'(uy_reg); end
            ST_D1: begin mul_en = 1'b1; mul_a = MUL_W'(a_reg[0]); mul_b = MUL_W'(b_reg[0]); end
            ST_D2: begin mul_en = 1'b1; mul_a = MUL_W'(a_reg[1]); mul_b = MUL_W'(b_reg[1]); end
            ST_D3: begin mul_en = 1'b1; mul_a = MUL_W'(a_reg[2]); mul_b = MUL_W'(b_reg[2]); end
            ST_C0: begin mul_en = 1'b1; mul_a = MUL_W'(a_reg[1]); mul_b = MUL_W'(b_reg[2]); end
            ST_C1: begin mul_en = 1'b1; mul_a = MUL_W'(a_reg[2]); mul_b = MUL_W'(b_reg[1]); end
            ST_C3: begin mul_en = 1'b1; mul_a = MUL_W'(a_reg[2]); mul_b = MUL_W'(b_reg[0]); end
            ST_C4: begin mul_en = div_done; mul_a = MUL_W'(a_reg[0]); mul_b = MUL_W'(b_reg[2]); end
            ST_C6: begin mul_en = 1'b1; mul_a = MUL_W'(a_reg[0]); mul_b = MUL_W'(b_reg[1]); end
            ST_C7: begin mul_en = div_done; mul_a = MUL_W'(a_reg[1]); mul_b = MUL_W'(b_reg[0]); end
            ST_M0: begin mul_en = 1'b1; mul_a = q_reg[j_reg]; mul_b = MUL_W'(orient_reg[i_reg ^ j_reg]); end
            ST_N0: begin mul_en = 1'b1; mul_a = p_reg[k_reg]; mul_b = p_reg[k_reg]; end
            default: mul_en = 1'b0;
        endcase
        mul_p = mul_a * mul_b;
    end

    // square root requests
    always_comb
    begin
        sq_start = 1'b0;
        sq_rad   = '0;
        case (state_reg)
            ST_P4: begin sq_start = acc_reg > $signed(PROD_W'(thr_reg)); sq_rad = acc_reg << L2_SH; end
            ST_Z3: begin sq_start = acc_reg > 0; sq_rad = acc_reg; end
            ST_D5: begin sq_start = t_val > 0; sq_rad = t_val << (FRAC_BITS + 1); end
            ST_N2: begin sq_start = 1'b1; sq_rad = acc_reg; end
            default: sq_start = 1'b0;
        endcase
    end

    // divider requests
    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            ST_P8, ST_P9:
            begin
                div_start = (state_reg == ST_P8) || div_done;
                div_num   = DIV_NUM_W'(prod_reg <<< CLAMP_SH);
                div_den   = den_reg;
            end
            ST_I0:
            begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(px_reg) <<< FRAC_BITS;
                div_den   = DIV_DEN_W'(rad_reg);
            end
            ST_I1:
            begin
                div_start = div_done;
                div_num   = DIV_NUM_W'(py_reg) <<< FRAC_BITS;
                div_den   = DIV_DEN_W'(rad_reg);
            end
            ST_C3, ST_C6, ST_C9:
            begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(acc_reg);
                div_den   = DIV_DEN_W'(s_reg);
            end
            ST_N4:
            begin
                div_start = 1'b1;
                div_num   = DIV_NUM_W'(p_reg[k_reg]) <<< FRAC_BITS;
                div_den   = DIV_DEN_W'(n_reg);
            end
            default: div_start = 1'b0;
        endcase
    end

    arq_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_rad),
        .done     (sq_done),
        .root     (sq_root)
    );

    arq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_cfg_reg <= CFG_W'(300);
            cx_cfg_reg  <= CFG_W'(320);
            cy_cfg_reg  <= CFG_W'(240);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RADIUS:   rad_cfg_reg <= cfg_data;
                CFG_CENTER_X: cx_cfg_reg  <= cfg_data;
                CFG_CENTER_Y: cy_cfg_reg  <= cfg_data;
                default:      rad_cfg_reg <= rad_cfg_reg;
            endcase
        end
    end

    // multiplier output register
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= mul_p;
        end
    end

    // sequencer and kept state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            orient_reg[0] <= QONE;
            orient_reg[1] <= '0;
            orient_reg[2] <= '0;
            orient_reg[3] <= '0;
            org_x_reg     <= '0;
            org_y_reg     <= '0;
            dragging_reg  <= 1'b0;
            rot_reg       <= 1'b0;
        end
        else
        begin
            case (state_reg)
                // take an event
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        rot_reg   <= 1'b0;
                        state_reg <= ST_DONE;
                        case (s_tuser)
                            OP_PRESS:
                            begin
                                dragging_reg <= 1'b1;
                                org_x_reg    <= in_x;
                                org_y_reg    <= in_y;
                            end
                            OP_MOVE:
                            begin
                                if (dragging_reg)
                                begin
                                    rot_reg    <= 1'b1;
                                    cur_x_reg  <= in_x;
                                    cur_y_reg  <= in_y;
                                    org_x_reg  <= in_x;
                                    org_y_reg  <= in_y;
                                    px_reg     <= org_x_reg;
                                    py_reg     <= -org_y_reg;
                                    pt_sel_reg <= 1'b0;
                                    rad_reg    <= (rad_cfg_reg < RAD_MIN) ? RAD_MIN : rad_cfg_reg;
                                    state_reg  <= ST_P0;
                                end
                            end
                            OP_RELEASE: dragging_reg <= 1'b0;
                            default:
                            begin
                                orient_reg[0] <= QONE;
                                orient_reg[1] <= '0;
                                orient_reg[2] <= '0;
                                orient_reg[3] <= '0;
                            end
                        endcase
                    end
                end
                // hold until the result stage is free
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                // squared length against the clamp circle
                ST_P0: state_reg <= ST_P1;
                ST_P1:
                begin
                    thr_reg   <= prod_reg[2*CFG_W-1:0];
                    state_reg <= ST_P2;
                end
                ST_P2:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= ST_P3;
                end
                ST_P3:
                begin
                    acc_reg   <= acc_reg + prod_reg;
                    state_reg <= ST_P4;
                end
                ST_P4: state_reg <= sq_start ? ST_P5 : ST_I0;
                // radial clamp
                ST_P5:
                begin
                    if (sq_done)
                    begin
                        state_reg <= ST_P6;
                    end
                end
                ST_P6: state_reg <= ST_P7;
                ST_P7:
                begin
                    den_reg   <= prod_reg[DIV_DEN_W-1:0];
                    state_reg <= ST_P8;
                end
                ST_P8: state_reg <= ST_P9;
                ST_P9:
                begin
                    if (div_done)
                    begin
                        ux_reg    <= U_W'(div_quot);
                        state_reg <= ST_P10;
                    end
                end
                ST_P10:
                begin
                    if (div_done)
                    begin
                        uy_reg    <= U_W'(div_quot);
                        state_reg <= ST_Z0;
                    end
                end
                // inside the circle: scale by the radius
                ST_I0: state_reg <= ST_I1;
                ST_I1:
                begin
                    if (div_done)
                    begin
                        ux_reg    <= U_W'(div_quot);
                        state_reg <= ST_I2;
                    end
                end
                ST_I2:
                begin
                    if (div_done)
                    begin
                        uy_reg    <= U_W'(div_quot);
                        state_reg <= ST_Z0;
                    end
                end
                // height on the sphere
                ST_Z0: state_reg <= ST_Z1;
                ST_Z1:
                begin
                    acc_reg   <= ONE_F2 - prod_reg;
                    state_reg <= ST_Z2;
                end
                ST_Z2:
                begin
                    acc_reg   <= acc_reg - prod_reg;
                    state_reg <= ST_Z3;
                end
                ST_Z3:
                begin
                    pos_reg   <= sq_start;
                    state_reg <= ST_Z4;
                end
                ST_Z4:
                begin
                    if (!pos_reg || sq_done)
                    begin
                        if (!pt_sel_reg)
                        begin
                            a_reg[0]   <= ux_reg;
                            a_reg[1]   <= uy_reg;
                            a_reg[2]   <= pos_reg ? U_W'(sq_root) : '0;
                            pt_sel_reg <= 1'b1;
                            px_reg     <= cur_x_reg;
                            py_reg     <= -cur_y_reg;
                            state_reg  <= ST_P0;
                        end
                        else
                        begin
                            b_reg[0]  <= ux_reg;
                            b_reg[1]  <= uy_reg;
                            b_reg[2]  <= pos_reg ? U_W'(sq_root) : '0;
                            state_reg <= ST_D1;
                        end
                    end
                end
                // dot product and half-angle term
                ST_D1: state_reg <= ST_D2;
                ST_D2:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= ST_D3;
                end
                ST_D3:
                begin
                    acc_reg   <= acc_reg + prod_reg;
                    state_reg <= ST_D4;
                end
                ST_D4:
                begin
                    acc_reg   <= acc_reg + prod_reg;
                    state_reg <= ST_D5;
                end
                ST_D5:
                begin
                    pos_reg   <= sq_start;
                    state_reg <= ST_D6;
                end
                ST_D6:
                begin
                    if (!pos_reg)
                    begin
                        s_reg     <= '0;
                        state_reg <= ST_QS;
                    end
                    else if (sq_done)
                    begin
                        s_reg     <= sq_root;
                        state_reg <= ST_QS;
                    end
                end
                // rotation scalar, or identity for opposite points
                ST_QS:
                begin
                    i_reg <= '0;
                    j_reg <= '0;
                    if (s_reg == '0)
                    begin
                        q_reg[0]  <= MUL_W'(QONE);
                        q_reg[1]  <= '0;
                        q_reg[2]  <= '0;
                        q_reg[3]  <= '0;
                        state_reg <= ST_M0;
                    end
                    else
                    begin
                        q_reg[0]  <= $signed(MUL_W'((s_reg + 1'b1) >> 1));
                        state_reg <= ST_C0;
                    end
                end
                // cross product over the half-angle term
                ST_C0: state_reg <= ST_C1;
                ST_C1:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= ST_C2;
                end
                ST_C2:
                begin
                    acc_reg   <= acc_reg - prod_reg;
                    state_reg <= ST_C3;
                end
                ST_C3: state_reg <= ST_C4;
                ST_C4:
                begin
                    if (div_done)
                    begin
                        q_reg[1]  <= MUL_W'(div_quot);
                        acc_reg   <= prod_reg;
                        state_reg <= ST_C5;
                    end
                end
                ST_C5:
                begin
                    acc_reg   <= acc_reg - prod_reg;
                    state_reg <= ST_C6;
                end
                ST_C6: state_reg <= ST_C7;
                ST_C7:
                begin
                    if (div_done)
                    begin
                        q_reg[2]  <= MUL_W'(div_quot);
                        acc_reg   <= prod_reg;
                        state_reg <= ST_C8;
                    end
                end
                ST_C8:
                begin
                    acc_reg   <= acc_reg - prod_reg;
                    state_reg <= ST_C9;
                end
                ST_C9: state_reg <= ST_C10;
                ST_C10:
                begin
                    if (div_done)
                    begin
                        q_reg[3]  <= MUL_W'(div_quot);
                        state_reg <= ST_M0;
                    end
                end
                // quaternion product, one term per pass
                ST_M0: state_reg <= ST_M1;
                ST_M1:
                begin
                    acc_reg <= (j_reg == '0) ? term : acc_reg + term;
                    if (j_reg == 2'd3)
                    begin
                        state_reg <= ST_M2;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_M0;
                    end
                end
                ST_M2:
                begin
                    p_reg[i_reg] <= MUL_W'(rnd_shr(acc_reg, PROD_SH));
                    j_reg        <= '0;
                    k_reg        <= '0;
                    if (i_reg == 2'd3)
                    begin
                        state_reg <= ST_N0;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_M0;
                    end
                end
                // squared norm
                ST_N0: state_reg <= ST_N1;
                ST_N1:
                begin
                    acc_reg <= ((k_reg == '0) ? '0 : acc_reg) + prod_reg;
                    if (k_reg == 2'd3)
                    begin
                        state_reg <= ST_N2;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_N0;
                    end
                end
                ST_N2: state_reg <= ST_N3;
                ST_N3:
                begin
                    if (sq_done)
                    begin
                        n_reg <= sq_root;
                        k_reg <= '0;
                        if (sq_root == '0)
                        begin
                            orient_reg[0] <= QONE;
                            orient_reg[1] <= '0;
                            orient_reg[2] <= '0;
                            orient_reg[3] <= '0;
                            state_reg     <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_N4;
                        end
                    end
                end
                // normalize and clamp each component
                ST_N4: state_reg <= ST_N5;
                ST_N5:
                begin
                    if (div_done)
                    begin
                        if (div_quot > DIV_Q_W'(QONE))
                        begin
                            orient_reg[k_reg] <= QONE;
                        end
                        else if (div_quot < -DIV_Q_W'(QONE))
                        begin
                            orient_reg[k_reg] <= -QONE;
                        end
                        else
                        begin
                            orient_reg[k_reg] <= Q_W'(div_quot);
                        end
                        if (k_reg == 2'd3)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= ST_N4;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_q_reg[0] <= orient_reg[0];
            out_q_reg[1] <= orient_reg[1];
            out_q_reg[2] <= orient_reg[2];
            out_q_reg[3] <= orient_reg[3];
            out_rot_reg  <= rot_reg;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {out_q_reg[3], out_q_reg[2], out_q_reg[1], out_q_reg[0]};
    assign m_tuser   = out_rot_reg;

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the arcball quaternion rotation unit
// Drives press, move, release and reset events on the input stream. A bit-true
// fixed-point predictor computes the orientation expected after each event,
// and every output item is compared field by field against it. Register
// settings change between phases, and both stream sides idle and stall.
// ----------------------------------------------------------------------------
module testbench;
    import arq_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               rot;
    } orient_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata = '0;
    logic [OP_W-1:0]      s_tuser = OP_PRESS;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [63:0]          m_tdata;
    logic [0:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_RADIUS;
    logic [CFG_W-1:0]     cfg_data = '0;

    // predictor state
    longint  quat_st[4];
    longint  origin_x, origin_y;
    bit      drag_on;
    longint  radius_cfg, ctr_x_cfg, ctr_y_cfg;
    orient_t pending_orient[$];

    int send_idle = 0;
    int recv_idle = 0;
    int hold_left = 0;
    int fail_count = 0;
    int events_sent = 0;
    int results_seen = 0;
    int rotations_seen = 0;
    int cycles = 0;

    arcball_quaternion_rotation_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // divide rounding half away from zero, den > 0
    function automatic longint round_div(input longint num, input longint den);
        longint unsigned m;
        longint unsigned q;
        m = (num < 0) ? longint'(-num) : num;
        q = (m + longint'(den / 2)) / longint'(den);
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    // map a center-relative screen point onto the unit sphere in Q14
    task automatic sphere_point(input longint px, input longint py_scr,
                                output longint u0, output longint u1, output longint u2);
        longint py, r, sr, l2, lq, den, sc, z2;
        py = -py_scr;
        r = (radius_cfg < 2) ? 2 : radius_cfg;
        sr = r - 1;
        l2 = px * px + py * py;
        if (l2 > sr * sr)
        begin
            lq = int_sqrt(longint'(l2) << 16);
            den = lq * r;
            sc = sr * (longint'(1) << (FRAC_BITS + 8));
            u0 = round_div(px * sc, den);
            u1 = round_div(py * sc, den);
        end
        else
        begin
            u0 = round_div(px * (longint'(1) << FRAC_BITS), r);
            u1 = round_div(py * (longint'(1) << FRAC_BITS), r);
        end
        z2 = (longint'(1) << (2 * FRAC_BITS)) - u0 * u0 - u1 * u1;
        u2 = (z2 > 0) ? longint'(int_sqrt(z2)) : 0;
    endtask

    // fold the shortest-arc rotation between origin and current point into the orientation
    task automatic rotate_orientation(input longint px, input longint py);
        longint a[3], b[3], q[4], o[4], p[4];
        longint d, t, s, n;
        longint unsigned n2;
        longint v;
        sphere_point(origin_x, origin_y, a[0], a[1], a[2]);
        sphere_point(px, py, b[0], b[1], b[2]);
        d = round_div(a[0] * b[0] + a[1] * b[1] + a[2] * b[2], longint'(1) << FRAC_BITS);
        t = (longint'(1) << FRAC_BITS) + d;
        s = (t > 0) ? longint'(int_sqrt((t * 2) << FRAC_BITS)) : 0;
        if (s == 0)
        begin
            q[0] = longint'(1) << FRAC_BITS;
            q[1] = 0; q[2] = 0; q[3] = 0;
        end
        else
        begin
            q[0] = round_div(s, 2);
            q[1] = round_div(a[1] * b[2] - a[2] * b[1], s);
            q[2] = round_div(a[2] * b[0] - a[0] * b[2], s);
            q[3] = round_div(a[0] * b[1] - a[1] * b[0], s);
        end
        for (int i = 0; i < 4; i++)
            o[i] = quat_st[i];
        p[0] = q[0] * o[0] - q[1] * o[1] - q[2] * o[2] - q[3] * o[3];
        p[1] = q[0] * o[1] + q[1] * o[0] + q[2] * o[3] - q[3] * o[2];
        p[2] = q[0] * o[2] - q[1] * o[3] + q[2] * o[0] + q[3] * o[1];
        p[3] = q[0] * o[3] + q[1] * o[2] - q[2] * o[1] + q[3] * o[0];
        n2 = 0;
        for (int i = 0; i < 4; i++)
        begin
            p[i] = round_div(p[i], longint'(1) << (FRAC_BITS - 8));
            n2 = n2 + longint'(p[i] * p[i]);
        end
        n = int_sqrt(n2);
        if (n == 0)
        begin
            quat_st[0] = 16384;
            quat_st[1] = 0; quat_st[2] = 0; quat_st[3] = 0;
        end
        else
            for (int i = 0; i < 4; i++)
            begin
                v = round_div(p[i] * 16384, n);
                if (v > 16384) v = 16384;
                if (v < -16384) v = -16384;
                quat_st[i] = v;
            end
    endtask

    // advance the predictor by one event and queue the orientation it yields
    task automatic predict_orientation(input logic [OP_W-1:0] op, input logic [11:0] px,
                                       input logic [11:0] py);
        longint cx, cy;
        orient_t e;
        cx = longint'(px) - ctr_x_cfg;
        cy = longint'(py) - ctr_y_cfg;
        e.rot = 1'b0;
        case (op)
            OP_PRESS:
            begin
                drag_on = 1'b1;
                origin_x = cx;
                origin_y = cy;
            end
            OP_MOVE:
                if (drag_on)
                begin
                    rotate_orientation(cx, cy);
                    origin_x = cx;
                    origin_y = cy;
                    e.rot = 1'b1;
                end
            OP_RELEASE:
                drag_on = 1'b0;
            default:
            begin
                quat_st[0] = 16384;
                quat_st[1] = 0; quat_st[2] = 0; quat_st[3] = 0;
            end
        endcase
        e.w = quat_st[0][15:0];
        e.x = quat_st[1][15:0];
        e.y = quat_st[2][15:0];
        e.z = quat_st[3][15:0];
        pending_orient.push_back(e);
    endtask

    // offer one event, idling first at random
    task automatic send_event(input logic [OP_W-1:0] op, input int px, input int py);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {12'(py), 12'(px)};
        do
            @(posedge clk);
        while (!s_tready);
        predict_orientation(op, 12'(px), 12'(py));
        events_sent++;
    endtask

    // hold stimulus until every expected item has come back
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_orient.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 12'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_RADIUS:   radius_cfg = value & 12'hfff;
            CFG_CENTER_X: ctr_x_cfg = value & 12'hfff;
            default:      ctr_y_cfg = value & 12'hfff;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_sphere(input int r, input int x0, input int y0);
        write_reg(CFG_RADIUS, r);
        write_reg(CFG_CENTER_X, x0);
        write_reg(CFG_CENTER_Y, y0);
    endtask

    // pointer coordinate: mostly around the center, sometimes anywhere
    function automatic int pick_coord(input longint ctr);
        int span;
        int v;
        if ($urandom_range(7) == 0)
            return $urandom_range(4095);
        span = (radius_cfg < 8) ? 8 : int'(radius_cfg) + int'(radius_cfg) / 4;
        v = int'(ctr) + $urandom_range(2 * span) - span;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v;
    endfunction

    // receiver: random stall, or a long hold when requested
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // compare each output item with the oldest expectation
    always @(posedge clk)
    begin
        orient_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_orient.size() == 0)
            begin
                $error("unexpected output item %h/%b", m_tdata, m_tuser);
                fail_count++;
            end
            else
            begin
                e = pending_orient.pop_front();
                results_seen++;
                if (m_tuser[0]) rotations_seen++;
                if (m_tdata[15:0] !== e.w)
                begin
                    $error("quat_w expected %0d got %0d", e.w, $signed(m_tdata[15:0]));
                    fail_count++;
                end
                if (m_tdata[31:16] !== e.x)
                begin
                    $error("quat_x expected %0d got %0d", e.x, $signed(m_tdata[31:16]));
                    fail_count++;
                end
                if (m_tdata[47:32] !== e.y)
                begin
                    $error("quat_y expected %0d got %0d", e.y, $signed(m_tdata[47:32]));
                    fail_count++;
                end
                if (m_tdata[63:48] !== e.z)
                begin
                    $error("quat_z expected %0d got %0d", e.z, $signed(m_tdata[63:48]));
                    fail_count++;
                end
                if (m_tuser[0] !== e.rot)
                begin
                    $error("rotated expected %0d got %0d", e.rot, m_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_directed();
        set_sphere(300, 320, 240);
        send_event(OP_MOVE, 400, 200);          // move with no drag
        send_event(OP_PRESS, 320, 240);
        send_event(OP_MOVE, 400, 200);
        send_event(OP_MOVE, 4095, 4095);        // far outside the sphere
        send_event(OP_MOVE, 0, 0);
        send_event(OP_PRESS, 20, 240);          // restart drag while dragging
        send_event(OP_MOVE, 620, 240);          // opposite points
        send_event(OP_MOVE, 320, 240);
        send_event(OP_MOVE, 320, 540);
        send_event(OP_RELEASE, 0, 4095);
        send_event(OP_MOVE, 100, 100);          // dropped after release
        send_event(OP_RESET, 4095, 0);
        send_event(OP_PRESS, 320, 240);
        send_event(OP_RESET, 0, 0);             // reset keeps the drag
        send_event(OP_MOVE, 330, 250);
        send_event(OP_RELEASE, 0, 0);
        // radius below minimum
        set_sphere(0, 0, 0);
        send_event(OP_PRESS, 0, 0);
        send_event(OP_MOVE, 1, 0);
        send_event(OP_MOVE, 4095, 4095);
        set_sphere(4095, 4095, 4095);
        send_event(OP_PRESS, 4095, 4095);
        send_event(OP_MOVE, 0, 0);
        send_event(OP_MOVE, 2000, 3000);
        send_event(OP_RELEASE, 0, 0);
    endtask

    // drag strokes with random content, plus stray events
    task automatic test_random(input int count);
        int done;
        int moves;
        done = 0;
        while (done < count)
        begin
            if ($urandom_range(9) < 8)
            begin
                send_event(OP_PRESS, pick_coord(ctr_x_cfg), pick_coord(ctr_y_cfg));
                moves = $urandom_range(1, 6);
                for (int i = 0; i < moves; i++)
                    send_event(OP_MOVE, pick_coord(ctr_x_cfg), pick_coord(ctr_y_cfg));
                if ($urandom_range(3) != 0)
                    send_event(OP_RELEASE, $urandom_range(4095), $urandom_range(4095));
                done += moves + 2;
            end
            else
            begin
                send_event(2'($urandom_range(3)), $urandom_range(4095), $urandom_range(4095));
                done++;
            end
        end
    endtask

    // stall the output long enough that the input backs up
    task automatic test_backpressure();
        drain_results();
        hold_left = 3000;
        send_event(OP_PRESS, 330, 250);
        for (int i = 0; i < 6; i++)
            send_event(OP_MOVE, pick_coord(ctr_x_cfg), pick_coord(ctr_y_cfg));
        send_event(OP_RELEASE, 0, 0);
    endtask

    task automatic test_pause();
        send_event(OP_PRESS, 300, 260);
        drain_results();
        send_event(OP_MOVE, 350, 200);
        drain_results();
        send_event(OP_RELEASE, 0, 0);
    endtask

    initial
    begin
        quat_st[0] = 16384;
        quat_st[1] = 0; quat_st[2] = 0; quat_st[3] = 0;
        origin_x = 0; origin_y = 0;
        drag_on = 1'b0;
        radius_cfg = 300; ctr_x_cfg = 320; ctr_y_cfg = 240;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle = 8; recv_idle = 69;
        test_directed();
        set_sphere(300, 320, 240);
        test_random(170);
        test_backpressure();

        send_idle = 69; recv_idle = 8;
        set_sphere(2, 2048, 2048);
        test_random(60);
        set_sphere($urandom_range(2, 4095), $urandom_range(4095), $urandom_range(4095));
        test_random(110);
        test_pause();

        send_idle = 0; recv_idle = 0;
        set_sphere(4095, 0, 4095);
        test_random(60);
        set_sphere($urandom_range(20, 600), $urandom_range(4095), $urandom_range(4095));
        test_random(130);

        drain_results();
        repeat (50) @(posedge clk);
        $display("covered %0d events, %0d outputs checked, %0d drag rotations",
                 events_sent, results_seen, rotations_seen);
        $display("radius extremes, several centers, stalls on both sides, long output hold");
        if (fail_count == 0 && pending_orient.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
sv/arq_pkg.sv
sv/arq_sqrt.sv
sv/arq_div.sv
sv/arcball_quaternion_rotation_unit.sv
verif/testbench.sv
